/* sv/ttp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_pkg
// shared types, constants and register codes for the triple timer block
// ----------------------------------------------------------------------------
package ttp_pkg;

  localparam int DEF_NUM_TIMERS   = 3;
  localparam int DEF_ELAPSED_BITS = 16;

  localparam int CNT_W = 24;
  localparam int PRE_W = 21;

  // tcsr bit positions
  localparam int B_TE   = 0;
  localparam int B_TOIE = 1;
  localparam int B_TCIE = 2;
  localparam int B_MODE = 4;
  localparam int B_TRM  = 9;
  localparam int B_PCE  = 15;
  localparam int B_TOF  = 20;
  localparam int B_TCF  = 21;

  localparam logic [3:0] MODE_PWM = 4'd7;
  localparam logic [3:0] MODE_WD0 = 4'd9;
  localparam logic [3:0] MODE_WD1 = 4'd10;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_TCSR = 2'd0;
  localparam logic [1:0] REG_TLR  = 2'd1;
  localparam logic [1:0] REG_TCPR = 2'd2;
  localparam logic [1:0] REG_TCR  = 2'd3;

  localparam logic [3:0] ADDR_PRELOAD = 4'd12;
  localparam logic [3:0] ADDR_PRECNT  = 4'd13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] elapsed_clocks;
    logic [3:0]  reg_addr;
    logic [23:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [23:0] read_data;
    logic [2:0]  compare_irq;
    logic [2:0]  overflow_irq;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch input item
    logic div_start;  // load dividend, clear quotient
    logic div_step;   // one quotient bit
    logic div_commit; // store remainder and count
    logic tmr_step;   // update one timer
    logic [1:0] tmr_idx;
    logic do_write;
    logic do_read;
    logic clr_irq;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       pre_on;
  } dp_stat_t;

endpackage

/* sv/ttp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_datapath
// timer registers, restoring prescaler divider and shared timer update unit
// ----------------------------------------------------------------------------
module ttp_datapath import ttp_pkg::*; #(
  parameter int NUM_TIMERS   = DEF_NUM_TIMERS,
  parameter int ELAPSED_BITS = DEF_ELAPSED_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t result
);

  logic [CNT_W-1:0] csr [3];
  logic [CNT_W-1:0] tlr [3];
  logic [CNT_W-1:0] tcpr [3];
  logic [CNT_W-1:0] tcr [3];
  logic [CNT_W-1:0] preload;
  logic [PRE_W-1:0] remainder;
  logic [PRE_W-1:0] precount;

  in_item_t         item;
  logic [23:0]      rd;
  logic [2:0]       cmp_irq;
  logic [2:0]       ovf_irq;

  // divider: dividend up to 22 bits, quotient shifted in msb first
  logic [21:0] dvd;
  logic [21:0] quot;
  logic [21:0] part;
  logic [21:0] divisor;
  logic [22:0] trial;

  logic [ELAPSED_BITS-1:0] elapsed;
  assign elapsed = item.elapsed_clocks[ELAPSED_BITS-1:0];
  assign divisor = {1'b0, preload[PRE_W-1:0]} + 22'd1;
  assign trial   = {part, dvd[21]};

  logic [1:0] an;
  logic [1:0] ar;
  logic       timer_ok;
  assign an = item.reg_addr[3:2];
  assign ar = item.reg_addr[1:0];
  assign timer_ok = (item.reg_addr < 4'd12) && (32'(an) < NUM_TIMERS);

  always_comb begin
    stat.kind   = item.kind;
    stat.pre_on = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (csr[i][B_TE] && csr[i][B_PCE]) stat.pre_on = 1'b1;
    end
  end

  // timer update for the selected timer
  logic [CNT_W-1:0] t_csr, t_cnt, t_csr_next, t_cnt_next;
  logic [CNT_W-1:0] t_ld, t_cp;
  logic [CNT_W-1:0] clocks;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] wrapped, over;
  logic             pwm, t_ovf, t_cmp;

  always_comb begin
    t_csr   = csr[cmd.tmr_idx];
    t_cnt   = tcr[cmd.tmr_idx];
    t_ld    = tlr[cmd.tmr_idx];
    t_cp    = tcpr[cmd.tmr_idx];
    pwm     = t_csr[B_MODE +: 4] == MODE_PWM;
    clocks  = t_csr[B_PCE] ? {2'b00, quot} : CNT_W'(elapsed);
    if (t_csr[B_PCE] && !stat.pre_on) clocks = '0;
    sum        = {1'b0, t_cnt} + {1'b0, clocks};
    t_csr_next = t_csr;
    t_ovf      = 1'b0;
    t_cmp      = 1'b0;
    wrapped    = sum[CNT_W-1:0];
    if (sum[CNT_W]) begin
      if (t_csr[B_TOIE]) t_ovf = 1'b1;
      else t_csr_next[B_TOF] = 1'b1;
      if (pwm && t_csr[B_TRM]) wrapped = t_ld + sum[CNT_W-1:0];
    end
    over       = wrapped - t_cp;
    t_cnt_next = wrapped;
    if (wrapped >= t_cp) begin
      t_cmp = t_csr[B_TCIE];
      t_csr_next[B_TCF] = 1'b1;
      if (!pwm && t_csr[B_TRM]) t_cnt_next = t_ld + over;
    end
  end

  // tcsr write rule
  logic [CNT_W-1:0] w_old, w_val, w_flags;
  logic [3:0]       w_mode;
  logic             w_load;
  always_comb begin
    w_old   = csr[an];
    w_val   = item.write_data;
    w_flags = '0;
    w_flags[B_TOF] = 1'b1;
    w_flags[B_TCF] = 1'b1;
    w_mode  = w_val[B_MODE +: 4];
    w_load  = 1'b0;
    if (!w_old[B_TE] && w_val[B_TE]) begin
      w_load = (w_mode <= 4'd3) || (w_mode == MODE_WD0) || (w_mode == MODE_WD1);
    end else if (w_old[B_TE] && !w_val[B_TE]) begin
      w_val = w_val | w_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        csr[i]  <= '0;
        tlr[i]  <= '0;
        tcpr[i] <= '0;
        tcr[i]  <= '0;
      end
      preload   <= '0;
      remainder <= '0;
      precount  <= '0;
      rd        <= '0;
      cmp_irq   <= '0;
      ovf_irq   <= '0;
    end else begin
      if (cmd.clr_irq) begin
        rd      <= '0;
        cmp_irq <= '0;
        ovf_irq <= '0;
      end
      if (cmd.div_commit) begin
        remainder <= part[PRE_W-1:0];
        precount  <= preload[PRE_W-1:0] - part[PRE_W-1:0];
      end
      if (cmd.tmr_step && t_csr[B_TE] && clocks != '0) begin
        csr[cmd.tmr_idx] <= t_csr_next;
        tcr[cmd.tmr_idx] <= t_cnt_next;
        cmp_irq[cmd.tmr_idx] <= t_cmp;
        ovf_irq[cmd.tmr_idx] <= t_ovf;
      end
      if (cmd.do_write) begin
        if (timer_ok) begin
          case (ar)
            REG_TCSR: begin
              csr[an] <= (w_val & ~w_flags) | (w_old & w_flags & ~w_val);
              if (w_load) tcr[an] <= tlr[an];
            end
            REG_TLR:  tlr[an]  <= item.write_data;
            REG_TCPR: tcpr[an] <= item.write_data;
            default:  tcr[an]  <= item.write_data;
          endcase
        end else if (item.reg_addr == ADDR_PRELOAD) begin
          preload <= item.write_data;
        end
      end
      if (cmd.do_read) begin
        if (timer_ok) begin
          case (ar)
            REG_TCSR: rd <= csr[an];
            REG_TLR:  rd <= tlr[an];
            REG_TCPR: rd <= tcpr[an];
            default:  rd <= tcr[an];
          endcase
        end else if (item.reg_addr == ADDR_PRELOAD) begin
          rd <= preload;
        end else if (item.reg_addr == ADDR_PRECNT) begin
          rd <= CNT_W'(precount);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
    if (cmd.div_start) begin
      dvd  <= {1'b0, remainder} + 22'(elapsed);
      part <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[20:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        part <= 22'(trial - {1'b0, divisor});
        quot <= {quot[20:0], 1'b1};
      end else begin
        part <= trial[21:0];
        quot <= {quot[20:0], 1'b0};
      end
    end else if (cmd.capture) begin
      quot <= '0;
    end
  end

  assign result.read_data    = rd;
  assign result.compare_irq  = cmp_irq;
  assign result.overflow_irq = ovf_irq;

endmodule

/* sv/ttp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_ctrl
// sequencer for item capture, prescaler division, timer updates and output
// ----------------------------------------------------------------------------
module ttp_ctrl import ttp_pkg::*; #(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_DIV, S_COMMIT, S_TIMER, S_OUT} state_t;

  state_t     state;
  logic [4:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.tmr_idx = cnt[1:0];
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        cmd.clr_irq = in_valid;
      end
      S_DISPATCH: begin
        cmd.do_write  = stat.kind == KIND_WRITE;
        cmd.do_read   = stat.kind == KIND_READ;
        cmd.div_start = stat.kind == KIND_TICK;
      end
      S_DIV:    cmd.div_step   = 1'b1;
      S_COMMIT: cmd.div_commit = stat.pre_on;
      S_TIMER:  cmd.tmr_step   = 1'b1;
      default:  cmd = cmd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          cnt <= '0;
          if (stat.kind == KIND_TICK) begin
            state <= S_DIV;
          end else begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd21) state <= S_COMMIT;
        end
        S_COMMIT: begin
          cnt   <= '0;
          state <= S_TIMER;
        end
        S_TIMER: begin
          cnt <= cnt + 5'd1;
          if (32'(cnt) == NUM_TIMERS - 1) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/triple_timer_with_prescaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_timer_with_prescaler
// three 24-bit timers sharing a 21-bit prescaler, driven by tick, write and
// read transactions
// ----------------------------------------------------------------------------
// channel | direction | payload     | handshake
// in      | into      | in_item_t   | in_valid / in_stall
// out     | out of    | out_item_t  | out_valid / out_stall
//
// a write or read transaction passes through accept, dispatch and output;
//   its result and out_valid are registered on leaving dispatch
// a tick passes through accept, dispatch, 22 quotient
//   bits from the restoring prescaler divider, a commit step, each
//   timer in turn through the shared timer update unit, and output; its
//   result and out_valid are registered on leaving the last timer step
// one transaction at a time; the next is taken once the result has gone
// rst is synchronous; all timer registers and the prescaler preload, remainder and count clear to zero
// out_stall holds the result and in_stall stays high until it is taken
// ----------------------------------------------------------------------------
module triple_timer_with_prescaler import ttp_pkg::*; #(
  parameter int NUM_TIMERS   = DEF_NUM_TIMERS,
  parameter int ELAPSED_BITS = DEF_ELAPSED_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ttp_ctrl #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // registers, divider and timer update
  ttp_datapath #(
    .NUM_TIMERS   (NUM_TIMERS),
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .result  (out_data)
  );

endmodule
